/* rtl/core/node_pool_free_list_assert.svh */
// Assertion macros for the node pool free list RTL.
// Included by files that check their own control logic; no other dependencies.
`ifndef NODE_POOL_FREE_LIST_ASSERT_SVH
`define NODE_POOL_FREE_LIST_ASSERT_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define NPFL_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("npfl: property violated");
// expr must never be true outside reset
`define NPFL_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("npfl: forbidden condition seen");
`else
`define NPFL_ASSERT(lbl, clk, rstn, prop)
`define NPFL_NEVER(lbl, clk, rstn, expr)
`endif
`endif

/* rtl/core/npfl_pkg.sv */
// Shared types and constants for the node pool free list.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package npfl_pkg;

    localparam int DATA_W   = 64;
    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int LINK_MAX = 32;   // link field never wider than this
    localparam int CMP_W    = 18;   // holds any index, count, DEPTH or their sum

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 3'd0,
        OP_FREE  = 3'd1,
        OP_READ  = 3'd2,
        OP_WRITE = 3'd3,
        OP_SHIFT = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_AL_LINK,
        S_AL_NEXT,
        S_FR_MERGE,
        S_RD_DATA,
        S_SH_START,
        S_SH_TMP,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [INDEX_W-1:0] entry_index;
        logic [INDEX_W-1:0] target_index;
        logic [COUNT_W-1:0] move_count;
        logic [DATA_W-1:0]  write_data;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  given_index;
        logic [DATA_W-1:0]   read_data;
    } rsp_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } mem_ctl_t;

    // width of the chain link kept in the low bits of an entry
    function automatic int link_bits(input int entry_bits);
        link_bits = (entry_bits < LINK_MAX) ? entry_bits : LINK_MAX;
    endfunction

endpackage

/* rtl/core/node_pool_free_list.sv */
// Node pool free list, top level: request sequencer, entry store, response register.
// Depends on npfl_pkg, npfl_ctrl and npfl_mem.
`timescale 1ns / 1ps
//
// Usage
//   Request channel (req_valid/req_ready/req): one operation per request:
//   alloc, free, read, write or shift of a run of entries. Response channel
//   (rsp_valid/rsp_ready/rsp): exactly one response per request, in order.
//   One request is in work at a time; req_ready is high only when idle.
// Flow (the store read is registered): write goes straight to the store;
//   read, free and alloc read the entry first, and alloc also gives the next
//   entry its end marker when the frontier advances; bad index/op or empty
//   shift finish at decode. A shift of the rotated window len walks g rotation
//   chains (g the gcd of len and the offset). After the response is handed to
//   the output register the block returns to idle for the next request.
//   All work funnels through the single store port pair and the one rotation
//   index unit.
// Reset: free head returns to entry 0; entry 0 reads as the end marker until
//   first written. No clearing pass; requests are taken right after reset.
// Stall: a finished response waits in the output register while the block
//   returns to idle and takes the next request; that one finishes and then
//   holds until the register drains.
//
module node_pool_free_list #(
    parameter int DEPTH      = 1024,   // 2 .. 1024 entries
    parameter int ENTRY_BITS = 64      // 16 .. 64 bits per entry
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  npfl_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output npfl_pkg::rsp_t rsp
);

    localparam int AW = $clog2(DEPTH);

    npfl_pkg::mem_ctl_t    mem_ctl;
    logic [AW-1:0]         mem_rd_addr;
    logic [AW-1:0]         mem_wr_addr;
    logic [ENTRY_BITS-1:0] mem_wr_data;
    logic [ENTRY_BITS-1:0] mem_rd_data;

    logic           res_valid;
    logic           res_ready;
    npfl_pkg::rsp_t res;

    // output register
    logic           rsp_valid_reg, rsp_valid_next;
    npfl_pkg::rsp_t rsp_reg, rsp_next;

    npfl_ctrl #(
        .DEPTH      (DEPTH),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_ctl     (mem_ctl),
        .mem_rd_addr (mem_rd_addr),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_data (mem_rd_data)
    );

    npfl_mem #(
        .DEPTH      (DEPTH),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mem_ctl),
        .rd_addr (mem_rd_addr),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    // register takes a new response when empty or draining this cycle
    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* rtl/core/npfl_mem.sv */
// Entry store: one write port, one registered read port.
// Depends on npfl_pkg. Entry 0 reads as the end marker until first written.
`timescale 1ns / 1ps

module npfl_mem #(
    parameter int DEPTH      = 1024,
    parameter int ENTRY_BITS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  npfl_pkg::mem_ctl_t           ctl,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [ENTRY_BITS-1:0]        wr_data,
    output logic [ENTRY_BITS-1:0]        rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int LB = npfl_pkg::link_bits(ENTRY_BITS);
    localparam logic [ENTRY_BITS-1:0] END_WORD = ENTRY_BITS'({LB{1'b1}});

    logic [ENTRY_BITS-1:0] mem [DEPTH];
    logic [ENTRY_BITS-1:0] q_reg;
    logic                  init0_reg;
    logic                  init0_next;
    logic                  end_sel_reg;
    logic                  end_sel_next;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    // entry 0 holds the end marker after reset without a clearing pass
    always_comb
    begin
        init0_next   = init0_reg | (ctl.wr && (wr_addr == AW'(0)));
        end_sel_next = end_sel_reg;
        if (ctl.rd)
        begin
            end_sel_next = (rd_addr == AW'(0)) && !init0_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init0_reg   <= 1'b0;
            end_sel_reg <= 1'b0;
        end
        else
        begin
            init0_reg   <= init0_next;
            end_sel_reg <= end_sel_next;
        end
    end

    assign rd_data = end_sel_reg ? END_WORD : q_reg;

endmodule

/* rtl/core/npfl_ctrl.sv */
// Sequencer for the node pool free list: decodes a request, drives the entry
// store and walks shift rotations with one shared index unit. Depends on npfl_pkg.
`timescale 1ns / 1ps
`include "node_pool_free_list_assert.svh"

module npfl_ctrl #(
    parameter int DEPTH      = 1024,
    parameter int ENTRY_BITS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  npfl_pkg::req_t               req,
    output logic                         res_valid,
    input  logic                         res_ready,
    output npfl_pkg::rsp_t               res,
    output npfl_pkg::mem_ctl_t           mem_ctl,
    output logic [$clog2(DEPTH)-1:0]     mem_rd_addr,
    output logic [$clog2(DEPTH)-1:0]     mem_wr_addr,
    output logic [ENTRY_BITS-1:0]        mem_wr_data,
    input  logic [ENTRY_BITS-1:0]        mem_rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int HW = $clog2(DEPTH + 1);
    localparam int LB = npfl_pkg::link_bits(ENTRY_BITS);
    localparam int CW = npfl_pkg::CMP_W;
    localparam int DW = npfl_pkg::DATA_W;
    localparam int IW = npfl_pkg::INDEX_W;
    localparam logic [ENTRY_BITS-1:0] LINK_MASK = {ENTRY_BITS{1'b1}} >> (ENTRY_BITS - LB);
    localparam logic [LB-1:0]         END_MARK  = {LB{1'b1}};
    localparam logic [CW-1:0]         DEPTH_C   = CW'(DEPTH);
    localparam logic [HW-1:0]         DEPTH_H   = HW'(DEPTH);

    npfl_pkg::state_t  state_reg, state_next;
    npfl_pkg::status_t status_reg, status_next;

    logic [npfl_pkg::OP_W-1:0]    op_reg, op_next;
    logic [IW-1:0]                idx_reg, idx_next;
    logic [IW-1:0]                tgt_reg, tgt_next;
    logic [npfl_pkg::COUNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]                wdata_reg, wdata_next;
    logic [HW-1:0]                head_reg, head_next;
    logic [IW-1:0]                given_reg, given_next;
    logic [DW-1:0]                rdata_reg, rdata_next;
    logic [AW-1:0]                lo_reg, lo_next;
    logic [HW-1:0]                len_reg, len_next;
    logic [AW-1:0]                off_reg, off_next;
    logic [AW-1:0]                start_reg, start_next;
    logic [AW-1:0]                cur_reg, cur_next;
    logic [AW-1:0]                src_reg, src_next;
    logic [HW-1:0]                moved_reg, moved_next;
    logic [ENTRY_BITS-1:0]        tmp_reg, tmp_next;

    // decode arithmetic
    logic [CW-1:0] idx_c, tgt_c, cnt_c, hi_c, lo_c, end_c, len_c, off_c;
    logic [CW-1:0] head_c, head_inc_c;
    logic [LB-1:0] link;
    logic [32:0]   link_w;
    logic [32:0]   head_w;
    logic [ENTRY_BITS-1:0] merged_end, merged_head;
    // shared rotation index unit
    logic [CW-1:0] sum_c, wrap_c;
    logic [AW-1:0] src_c;
    logic [HW-1:0] moved_inc;
    logic [AW-1:0] cur_addr;

    assign idx_c      = CW'(idx_reg);
    assign tgt_c      = CW'(tgt_reg);
    assign cnt_c      = CW'(cnt_reg);
    assign hi_c       = (idx_c > tgt_c) ? idx_c : tgt_c;
    assign lo_c       = (idx_c < tgt_c) ? idx_c : tgt_c;
    assign end_c      = hi_c + cnt_c;
    assign len_c      = end_c - lo_c;
    assign off_c      = (idx_c < tgt_c) ? cnt_c : (len_c - cnt_c);
    assign head_c     = CW'(head_reg);
    assign head_inc_c = head_c + CW'(1);
    assign link       = mem_rd_data[LB-1:0];
    assign link_w     = 33'(link);
    assign head_w     = 33'(head_reg);
    assign merged_end  = (mem_rd_data & ~LINK_MASK) | ENTRY_BITS'(END_MARK);
    assign merged_head = (mem_rd_data & ~LINK_MASK) | ENTRY_BITS'(head_w[LB-1:0]);

    assign sum_c     = CW'(cur_reg) + CW'(off_reg);
    assign wrap_c    = (sum_c >= CW'(len_reg)) ? (sum_c - CW'(len_reg)) : sum_c;
    assign src_c     = wrap_c[AW-1:0];
    assign moved_inc = moved_reg + HW'(1);
    assign cur_addr  = lo_reg + cur_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= npfl_pkg::S_IDLE;
            head_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        idx_reg    <= idx_next;
        tgt_reg    <= tgt_next;
        cnt_reg    <= cnt_next;
        wdata_reg  <= wdata_next;
        status_reg <= status_next;
        given_reg  <= given_next;
        rdata_reg  <= rdata_next;
        lo_reg     <= lo_next;
        len_reg    <= len_next;
        off_reg    <= off_next;
        start_reg  <= start_next;
        cur_reg    <= cur_next;
        src_reg    <= src_next;
        moved_reg  <= moved_next;
        tmp_reg    <= tmp_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        idx_next    = idx_reg;
        tgt_next    = tgt_reg;
        cnt_next    = cnt_reg;
        wdata_next  = wdata_reg;
        head_next   = head_reg;
        status_next = status_reg;
        given_next  = given_reg;
        rdata_next  = rdata_reg;
        lo_next     = lo_reg;
        len_next    = len_reg;
        off_next    = off_reg;
        start_next  = start_reg;
        cur_next    = cur_reg;
        src_next    = src_reg;
        moved_next  = moved_reg;
        tmp_next    = tmp_reg;
        req_ready   = 1'b0;
        res_valid   = 1'b0;
        mem_ctl     = '0;
        mem_rd_addr = '0;
        mem_wr_addr = '0;
        mem_wr_data = '0;

        unique case (state_reg)
            npfl_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next    = req.op;
                    idx_next   = req.entry_index;
                    tgt_next   = req.target_index;
                    cnt_next   = req.move_count;
                    wdata_next = req.write_data;
                    state_next = npfl_pkg::S_DECODE;
                end
            end

            npfl_pkg::S_DECODE:
            begin
                status_next = npfl_pkg::ST_OK;
                given_next  = '0;
                rdata_next  = '0;
                state_next  = npfl_pkg::S_DONE;
                unique case (op_reg) inside
                    npfl_pkg::OP_ALLOC:
                    begin
                        if (head_reg == DEPTH_H)
                        begin
                            status_next = npfl_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_ctl.rd  = 1'b1;
                            mem_rd_addr = head_reg[AW-1:0];
                            state_next  = npfl_pkg::S_AL_LINK;
                        end
                    end
                    npfl_pkg::OP_FREE, npfl_pkg::OP_READ:
                    begin
                        if (idx_c >= DEPTH_C)
                        begin
                            status_next = npfl_pkg::ST_RANGE;
                        end
                        else
                        begin
                            mem_ctl.rd  = 1'b1;
                            mem_rd_addr = idx_c[AW-1:0];
                            state_next  = (op_reg == npfl_pkg::OP_FREE) ?
                                          npfl_pkg::S_FR_MERGE : npfl_pkg::S_RD_DATA;
                        end
                    end
                    npfl_pkg::OP_WRITE:
                    begin
                        if (idx_c >= DEPTH_C)
                        begin
                            status_next = npfl_pkg::ST_RANGE;
                        end
                        else
                        begin
                            mem_ctl.wr  = 1'b1;
                            mem_wr_addr = idx_c[AW-1:0];
                            mem_wr_data = wdata_reg[ENTRY_BITS-1:0];
                        end
                    end
                    npfl_pkg::OP_SHIFT:
                    begin
                        if (end_c > DEPTH_C)
                        begin
                            status_next = npfl_pkg::ST_RANGE;
                        end
                        else if ((idx_reg != tgt_reg) && (cnt_c != '0))
                        begin
                            lo_next    = lo_c[AW-1:0];
                            len_next   = len_c[HW-1:0];
                            off_next   = off_c[AW-1:0];
                            start_next = '0;
                            moved_next = '0;
                            state_next = npfl_pkg::S_SH_START;
                        end
                    end
                    default:
                    begin
                        status_next = npfl_pkg::ST_RANGE;
                    end
                endcase
            end

            npfl_pkg::S_AL_LINK:
            begin
                given_next = head_c[IW-1:0];
                state_next = npfl_pkg::S_DONE;
                if (link == END_MARK)
                begin
                    // frontier moves up one entry; mark it unless past the end
                    head_next = head_inc_c[HW-1:0];
                    if (head_inc_c < DEPTH_C)
                    begin
                        mem_ctl.rd  = 1'b1;
                        mem_rd_addr = head_inc_c[AW-1:0];
                        state_next  = npfl_pkg::S_AL_NEXT;
                    end
                end
                else if (link_w < 33'(DEPTH))
                begin
                    head_next = link_w[HW-1:0];
                end
                else
                begin
                    head_next = DEPTH_H;
                end
            end

            npfl_pkg::S_AL_NEXT:
            begin
                mem_ctl.wr  = 1'b1;
                mem_wr_addr = head_reg[AW-1:0];
                mem_wr_data = merged_end;
                state_next  = npfl_pkg::S_DONE;
            end

            npfl_pkg::S_FR_MERGE:
            begin
                mem_ctl.wr  = 1'b1;
                mem_wr_addr = idx_c[AW-1:0];
                mem_wr_data = merged_head;
                head_next   = idx_c[HW-1:0];
                state_next  = npfl_pkg::S_DONE;
            end

            npfl_pkg::S_RD_DATA:
            begin
                rdata_next = DW'(mem_rd_data);
                state_next = npfl_pkg::S_DONE;
            end

            // rotation by cycle following: each chain opens at start_reg
            npfl_pkg::S_SH_START:
            begin
                mem_ctl.rd  = 1'b1;
                mem_rd_addr = lo_reg + start_reg;
                cur_next    = start_reg;
                state_next  = npfl_pkg::S_SH_TMP;
            end

            npfl_pkg::S_SH_TMP:
            begin
                tmp_next   = mem_rd_data;
                state_next = npfl_pkg::S_SH_RD;
            end

            npfl_pkg::S_SH_RD:
            begin
                if (src_c == start_reg)
                begin
                    // chain closes: saved head of chain goes in last
                    mem_ctl.wr  = 1'b1;
                    mem_wr_addr = cur_addr;
                    mem_wr_data = tmp_reg;
                    moved_next  = moved_inc;
                    if (moved_inc == len_reg)
                    begin
                        state_next = npfl_pkg::S_DONE;
                    end
                    else
                    begin
                        start_next = start_reg + AW'(1);
                        state_next = npfl_pkg::S_SH_START;
                    end
                end
                else
                begin
                    mem_ctl.rd  = 1'b1;
                    mem_rd_addr = lo_reg + src_c;
                    src_next    = src_c;
                    state_next  = npfl_pkg::S_SH_WR;
                end
            end

            npfl_pkg::S_SH_WR:
            begin
                mem_ctl.wr  = 1'b1;
                mem_wr_addr = cur_addr;
                mem_wr_data = mem_rd_data;
                cur_next    = src_reg;
                moved_next  = moved_inc;
                state_next  = npfl_pkg::S_SH_RD;
            end

            npfl_pkg::S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = npfl_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = npfl_pkg::S_IDLE;
            end
        endcase
    end

    assign res.status      = status_reg;
    assign res.given_index = given_reg;
    assign res.read_data   = rdata_reg;

    `NPFL_NEVER(a_rw_excl, clk, rst_n, mem_ctl.rd && mem_ctl.wr)
    `NPFL_NEVER(a_head_rng, clk, rst_n, head_reg > DEPTH_H)
    `NPFL_NEVER(a_busy_excl, clk, rst_n, req_ready && res_valid)
    `NPFL_ASSERT(a_shift_cnt, clk, rst_n, (state_reg == npfl_pkg::S_SH_RD) |-> (moved_reg < len_reg))

endmodule
